// File: rtl/core/tbrd_pkg.sv
`default_nettype none

package tbrd_pkg;

    localparam int CHANNELS = 2;
    localparam int CNT_W    = 32;
    localparam int SCALE_W  = 8;
    localparam int PROD_W   = CNT_W + SCALE_W;
    localparam int SW_W     = 2;
    localparam int MASK_W   = 2;
    localparam int FUNC_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CNT_W-1:0]   COUNT_MAX        = {CNT_W{1'b1}};
    localparam logic [SCALE_W-1:0] RESET_MULTIPLE   = 8'd20;
    localparam logic [SCALE_W-1:0] RESET_LEVEL      = 8'd1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE = 3'd0,
        FUNC_BEGIN  = 3'd1,
        FUNC_CLAMP  = 3'd2,
        FUNC_STOP   = 3'd3,
        FUNC_READ   = 3'd4
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BREAK_TYPE_IS_DOWN = 2'd0,
        CFG_BOARD_IS_DOWN      = 2'd1,
        CFG_TENSION_MULTIPLE   = 2'd2,
        CFG_BREAK_LEVEL        = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

// File: rtl/core/thread_break_ratio_detector.sv
`default_nettype none
// an item passes from the input register through the single compute stage to the result
// register; the state update happens on the same edge as the result load
// throughput: one item per cycle while i_ready does not hold a result back
// reset: synchronous active-low i_rst_n clears all counters and flags, restores the
// register defaults and empties both stages

module thread_break_ratio_detector (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration
    input  wire logic                               i_cfg_we,
    input  wire logic [tbrd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [tbrd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // item in
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [tbrd_pkg::FUNC_W-1:0]        i_func,
    input  wire logic                               i_channel,
    input  wire logic [tbrd_pkg::SW_W-1:0]          i_upper_switches,
    input  wire logic [tbrd_pkg::SW_W-1:0]          i_lower_switches,
    // result out
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic                                    o_broken,
    output logic [tbrd_pkg::MASK_W-1:0]             o_broken_mask
);

    localparam int CH    = tbrd_pkg::CHANNELS;
    localparam int CNT_W = tbrd_pkg::CNT_W;

    // configuration registers
    logic                             r_break_type_is_down;
    logic                             r_board_is_down;
    logic [tbrd_pkg::SCALE_W-1:0]     r_tension_multiple;
    logic [tbrd_pkg::SCALE_W-1:0]     r_break_level;

    // input stage
    logic                             r_in_valid;
    logic [tbrd_pkg::FUNC_W-1:0]      r_func;
    logic                             r_channel;
    logic [tbrd_pkg::SW_W-1:0]        r_upper;
    logic [tbrd_pkg::SW_W-1:0]        r_lower;

    // channel state
    logic [CH-1:0][CNT_W-1:0]         r_hit_sum;
    logic [CH-1:0][CNT_W-1:0]         r_count;
    logic [CH-1:0]                    r_flag;
    logic [CH-1:0]                    r_sampling;

    logic [CH-1:0][CNT_W-1:0]         n_hit_sum;
    logic [CH-1:0][CNT_W-1:0]         n_count;
    logic [CH-1:0]                    n_flag;
    logic [CH-1:0]                    n_sampling;
    logic                             n_broken;
    logic [tbrd_pkg::MASK_W-1:0]      n_mask;

    // result stage
    logic                             r_out_valid;
    logic                             r_broken;
    logic [tbrd_pkg::MASK_W-1:0]      r_mask;

    logic                             adv;
    logic                             do_item;
    logic                             works;
    logic [tbrd_pkg::SW_W-1:0]        sel;
    logic [tbrd_pkg::SW_W+CH-1:0]     sel_ext;
    logic [CH+tbrd_pkg::MASK_W-1:0]   flag_ext;
    logic [CH+tbrd_pkg::MASK_W-1:0]   held_ext;
    logic [CH-1:0][tbrd_pkg::PROD_W-1:0] lhs;
    logic [CH-1:0][tbrd_pkg::PROD_W-1:0] rhs;

    assign adv      = !r_out_valid || i_ready;
    assign do_item  = r_in_valid && adv;
    assign o_ready  = !r_in_valid || adv;
    assign o_valid  = r_out_valid;
    assign o_broken = r_broken;
    assign o_broken_mask = r_mask;

    assign works    = (r_break_type_is_down == r_board_is_down);
    assign sel      = r_break_type_is_down ? r_lower : r_upper;
    // channels past the switch field see a low switch
    assign sel_ext  = {{CH{1'b0}}, sel};
    assign held_ext = {{tbrd_pkg::MASK_W{1'b0}}, r_flag};

    always_comb begin
        for (int i = 0; i < CH; i++) begin
            lhs[i] = {{tbrd_pkg::SCALE_W{1'b0}}, r_hit_sum[i]}
                   * {{CNT_W{1'b0}}, r_tension_multiple};
            rhs[i] = {{tbrd_pkg::SCALE_W{1'b0}}, r_count[i]}
                   * {{CNT_W{1'b0}}, r_break_level};
        end
    end

    always_comb begin
        n_hit_sum  = r_hit_sum;
        n_count    = r_count;
        n_flag     = r_flag;
        n_sampling = r_sampling;
        n_broken   = 1'b0;
        unique case (r_func)
            tbrd_pkg::FUNC_SAMPLE: begin
                if (works) begin
                    for (int i = 0; i < CH; i++) begin
                        // hold both counters if either would wrap
                        if (r_sampling[i] && r_count[i] != tbrd_pkg::COUNT_MAX
                            && !(sel_ext[i] && r_hit_sum[i] == tbrd_pkg::COUNT_MAX)) begin
                            n_hit_sum[i] = r_hit_sum[i] + CNT_W'(sel_ext[i]);
                            n_count[i]   = r_count[i] + CNT_W'(1);
                        end
                    end
                end
            end
            tbrd_pkg::FUNC_BEGIN, tbrd_pkg::FUNC_STOP: begin
                n_hit_sum  = '0;
                n_count    = '0;
                n_flag     = '0;
                n_sampling = (r_func == tbrd_pkg::FUNC_BEGIN) ? {CH{1'b1}} : '0;
            end
            tbrd_pkg::FUNC_CLAMP: begin
                for (int i = 0; i < CH; i++) begin
                    if (works && r_sampling[i]) begin
                        n_flag[i] = (lhs[i] < rhs[i]);
                    end else begin
                        n_flag[i] = 1'b0;
                        if (works) begin
                            n_sampling[i] = 1'b1;
                        end
                    end
                end
                n_hit_sum = '0;
                n_count   = '0;
            end
            tbrd_pkg::FUNC_READ: begin
                for (int i = 0; i < CH; i++) begin
                    if (int'(r_channel) == i) begin
                        n_broken  = r_flag[i];
                        n_flag[i] = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        flag_ext = {{tbrd_pkg::MASK_W{1'b0}}, n_flag};
        n_mask   = flag_ext[tbrd_pkg::MASK_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_break_type_is_down <= 1'b0;
            r_board_is_down      <= 1'b0;
            r_tension_multiple   <= tbrd_pkg::RESET_MULTIPLE;
            r_break_level        <= tbrd_pkg::RESET_LEVEL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tbrd_pkg::CFG_BREAK_TYPE_IS_DOWN: r_break_type_is_down <= i_cfg_data[0];
                tbrd_pkg::CFG_BOARD_IS_DOWN:      r_board_is_down      <= i_cfg_data[0];
                tbrd_pkg::CFG_TENSION_MULTIPLE:   r_tension_multiple   <= i_cfg_data;
                tbrd_pkg::CFG_BREAK_LEVEL:        r_break_level        <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hit_sum   <= '0;
            r_count     <= '0;
            r_flag      <= '0;
            r_sampling  <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (do_item) begin
                r_hit_sum  <= n_hit_sum;
                r_count    <= n_count;
                r_flag     <= n_flag;
                r_sampling <= n_sampling;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_func    <= i_func;
            r_channel <= i_channel;
            r_upper   <= i_upper_switches;
            r_lower   <= i_lower_switches;
        end
        if (do_item) begin
            r_broken <= n_broken;
            r_mask   <= n_mask;
        end
    end

    a_broken_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_item && r_func != tbrd_pkg::FUNC_READ |=> !o_broken)
        else $error("broken set for an item that is not a read");

    // a held result shows the flags that its own item left behind
    a_mask_tracks_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_broken_mask == held_ext[tbrd_pkg::MASK_W-1:0])
        else $error("held mask differs from channel flags");

    a_hits_within_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit_sum[0] <= r_count[0])
        else $error("hit sum exceeds sample count");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !do_item |=> $stable(r_hit_sum) && $stable(r_count) && $stable(r_flag))
        else $error("channel state changed without an item");

    a_begin_starts_sampling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_item && r_func == tbrd_pkg::FUNC_BEGIN |=> &r_sampling && r_flag == '0)
        else $error("begin did not start sampling on all channels");

endmodule

`default_nettype wire

// File: dv/thread_break_ratio_detector_tb.sv
module thread_break_ratio_detector_tb;

    localparam int NUM_PHASES      = 8;
    localparam int OPS_PER_PHASE   = 125;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int SEND_IDLE_PCT   = 37;
    localparam int RECV_IDLE_PCT   = 87;

    typedef struct packed {
        logic [tbrd_pkg::FUNC_W-1:0] func;
        logic                        channel;
        logic [tbrd_pkg::SW_W-1:0]   upper;
        logic [tbrd_pkg::SW_W-1:0]   lower;
    } t_op_item;

    typedef struct packed {
        logic                        broken;
        logic [tbrd_pkg::MASK_W-1:0] mask;
    } t_break_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_we = 1'b0;
    logic [tbrd_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [tbrd_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            i_valid = 1'b0;
    logic                            o_ready;
    logic [tbrd_pkg::FUNC_W-1:0]     i_func = '0;
    logic                            i_channel = 1'b0;
    logic [tbrd_pkg::SW_W-1:0]       i_upper_switches = '0;
    logic [tbrd_pkg::SW_W-1:0]       i_lower_switches = '0;
    logic                            o_valid;
    logic                            i_ready = 1'b0;
    logic                            o_broken;
    logic [tbrd_pkg::MASK_W-1:0]     o_broken_mask;

    // shadow of the detector state and registers
    logic [tbrd_pkg::CNT_W-1:0]   hit_tally [tbrd_pkg::CHANNELS];
    logic [tbrd_pkg::CNT_W-1:0]   tick_tally [tbrd_pkg::CHANNELS];
    logic                         break_seen [tbrd_pkg::CHANNELS];
    logic                         sampling [tbrd_pkg::CHANNELS];
    logic                         cfg_lower_mode = 1'b0;
    logic                         cfg_lower_board = 1'b0;
    logic [tbrd_pkg::SCALE_W-1:0] cfg_multiple = tbrd_pkg::RESET_MULTIPLE;
    logic [tbrd_pkg::SCALE_W-1:0] cfg_level = tbrd_pkg::RESET_LEVEL;

    t_op_item      pending_ops [$];
    t_break_result expected_results [$];
    int            counted_ops = 0;
    int            mismatch_count = 0;
    int            cycle_count = 0;
    int            send_idle_pct = SEND_IDLE_PCT;
    int            recv_idle_pct = RECV_IDLE_PCT;

    thread_break_ratio_detector u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_func           (i_func),
        .i_channel        (i_channel),
        .i_upper_switches (i_upper_switches),
        .i_lower_switches (i_lower_switches),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_broken         (o_broken),
        .o_broken_mask    (o_broken_mask)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_break_result predict_break(t_op_item op);
        t_break_result               r;
        logic                        works;
        logic [tbrd_pkg::SW_W-1:0]   sw;
        logic                        ten;
        logic [tbrd_pkg::PROD_W-1:0] hit_prod;
        logic [tbrd_pkg::PROD_W-1:0] tick_prod;
        r = '0;
        works = (cfg_lower_mode == cfg_lower_board);
        sw = cfg_lower_mode ? op.lower : op.upper;
        case (op.func)
            tbrd_pkg::FUNC_SAMPLE: begin
                if (works) begin
                    for (int c = 0; c < tbrd_pkg::CHANNELS; c++) begin
                        if (sampling[c]) begin
                            ten = (c < tbrd_pkg::SW_W) ? sw[c] : 1'b0;
                            // both counters hold if either would wrap
                            if ({1'b0, hit_tally[c]} + ten <= {1'b0, tbrd_pkg::COUNT_MAX} &&
                                tick_tally[c] != tbrd_pkg::COUNT_MAX) begin
                                hit_tally[c] = hit_tally[c] + ten;
                                tick_tally[c] = tick_tally[c] + 1'b1;
                            end
                        end
                    end
                end
            end
            tbrd_pkg::FUNC_BEGIN, tbrd_pkg::FUNC_STOP: begin
                for (int c = 0; c < tbrd_pkg::CHANNELS; c++) begin
                    hit_tally[c] = '0;
                    tick_tally[c] = '0;
                    break_seen[c] = 1'b0;
                    sampling[c] = (op.func == tbrd_pkg::FUNC_BEGIN);
                end
            end
            tbrd_pkg::FUNC_CLAMP: begin
                for (int c = 0; c < tbrd_pkg::CHANNELS; c++) begin
                    if (works && sampling[c]) begin
                        hit_prod = tbrd_pkg::PROD_W'(hit_tally[c])
                                 * tbrd_pkg::PROD_W'(cfg_multiple);
                        tick_prod = tbrd_pkg::PROD_W'(tick_tally[c])
                                  * tbrd_pkg::PROD_W'(cfg_level);
                        break_seen[c] = hit_prod < tick_prod;
                    end else begin
                        break_seen[c] = 1'b0;
                        if (works)
                            sampling[c] = 1'b1;
                    end
                    hit_tally[c] = '0;
                    tick_tally[c] = '0;
                end
            end
            tbrd_pkg::FUNC_READ: begin
                if (op.channel < tbrd_pkg::CHANNELS) begin
                    r.broken = break_seen[op.channel];
                    break_seen[op.channel] = 1'b0;
                end
            end
            default: ;
        endcase
        for (int c = 0; c < tbrd_pkg::CHANNELS && c < tbrd_pkg::MASK_W; c++)
            r.mask[c] = break_seen[c];
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic queue_op(logic [tbrd_pkg::FUNC_W-1:0] func, logic channel,
                            logic [tbrd_pkg::SW_W-1:0] upper,
                            logic [tbrd_pkg::SW_W-1:0] lower);
        pending_ops.push_back(t_op_item'{func: func, channel: channel, upper: upper,
                                         lower: lower});
        if (func <= tbrd_pkg::FUNC_READ)
            counted_ops++;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_ops.size() != 0 || i_valid || expected_results.size() != 0);
    endtask

    task automatic write_reg(tbrd_pkg::t_cfg_idx idx, logic [tbrd_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            tbrd_pkg::CFG_BREAK_TYPE_IS_DOWN: cfg_lower_mode = val[0];
            tbrd_pkg::CFG_BOARD_IS_DOWN:      cfg_lower_board = val[0];
            tbrd_pkg::CFG_TENSION_MULTIPLE:   cfg_multiple = val[tbrd_pkg::SCALE_W-1:0];
            tbrd_pkg::CFG_BREAK_LEVEL:        cfg_level = val[tbrd_pkg::SCALE_W-1:0];
            default: ;
        endcase
    endtask

    // driver
    always @(posedge i_clk) begin
        t_op_item nxt;
        if (i_rst_n && (!i_valid || o_ready)) begin
            if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_ops.pop_front();
                i_valid <= 1'b1;
                i_func <= nxt.func;
                i_channel <= nxt.channel;
                i_upper_switches <= nxt.upper;
                i_lower_switches <= nxt.lower;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on each accepted item, then checks each accepted result
    always @(posedge i_clk) begin
        t_break_result want;
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && i_valid && o_ready)
            expected_results.push_back(predict_break(t_op_item'{func: i_func,
                channel: i_channel, upper: i_upper_switches, lower: i_lower_switches}));
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with no item waiting");
            end else begin
                want = expected_results.pop_front();
                if (o_broken !== want.broken)
                    report_mismatch($sformatf("broken got %b want %b", o_broken, want.broken));
                if (o_broken_mask !== want.mask)
                    report_mismatch($sformatf("broken_mask got %b want %b",
                                              o_broken_mask, want.mask));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int                           phase_start;
        int                           n;
        int                           pct [tbrd_pkg::CHANNELS];
        logic [tbrd_pkg::SW_W-1:0]    up;
        logic [tbrd_pkg::SW_W-1:0]    lo;
        logic                         set_mode;
        logic                         set_board;
        logic [tbrd_pkg::SCALE_W-1:0] set_mult;
        logic [tbrd_pkg::SCALE_W-1:0] set_level;

        for (int c = 0; c < tbrd_pkg::CHANNELS; c++) begin
            hit_tally[c] = '0;
            tick_tally[c] = '0;
            break_seen[c] = 1'b0;
            sampling[c] = 1'b0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part with the register defaults
        queue_op(tbrd_pkg::FUNC_READ, 1'b0, '0, '0);
        queue_op(tbrd_pkg::FUNC_SAMPLE, 1'b0, '1, '1);      // sampling off, nothing counts
        queue_op(tbrd_pkg::FUNC_CLAMP, 1'b1, '0, '0);       // clamp with sampling off arms it
        queue_op(tbrd_pkg::FUNC_SAMPLE, 1'b0, 2'b11, 2'b00);
        queue_op(tbrd_pkg::FUNC_SAMPLE, 1'b1, 2'b00, 2'b11);
        queue_op(tbrd_pkg::FUNC_CLAMP, 1'b0, '0, '0);
        queue_op(tbrd_pkg::FUNC_SAMPLE, 1'b0, 2'b10, 2'b01);
        queue_op(tbrd_pkg::FUNC_SAMPLE, 1'b1, 2'b00, 2'b11);
        queue_op(tbrd_pkg::FUNC_SAMPLE, 1'b0, 2'b00, 2'b00);
        queue_op(tbrd_pkg::FUNC_CLAMP, 1'b1, '1, '1);       // channel 0 breaks
        queue_op(tbrd_pkg::FUNC_READ, 1'b1, '0, '0);
        queue_op(tbrd_pkg::FUNC_READ, 1'b0, '0, '0);
        queue_op(tbrd_pkg::FUNC_READ, 1'b0, '1, '1);
        queue_op(tbrd_pkg::FUNC_CLAMP, 1'b0, '0, '0);       // zero samples, no break
        queue_op(tbrd_pkg::FUNC_SAMPLE, 1'b1, '0, '0);
        queue_op(tbrd_pkg::FUNC_CLAMP, 1'b0, '0, '0);       // both break
        queue_op(tbrd_pkg::FUNC_READ, 1'b1, '1, '0);
        queue_op(tbrd_pkg::FUNC_BEGIN, 1'b1, '1, '1);
        queue_op(tbrd_pkg::FUNC_SAMPLE, 1'b0, 2'b01, 2'b10);
        queue_op(tbrd_pkg::FUNC_STOP, 1'b0, '1, '1);
        queue_op(tbrd_pkg::FUNC_SAMPLE, 1'b1, '1, '1);
        queue_op(tbrd_pkg::FUNC_CLAMP, 1'b0, '0, '0);
        for (int u = tbrd_pkg::FUNC_READ + 1; u < 2 ** tbrd_pkg::FUNC_W; u++)
            queue_op(tbrd_pkg::FUNC_W'(u), 1'b1, '1, '1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // sender holds off here until every result is back
            wait_drained();
            if (p < 3) begin
                send_idle_pct = SEND_IDLE_PCT;
                recv_idle_pct = RECV_IDLE_PCT;
            end else if (p < 6) begin
                send_idle_pct = RECV_IDLE_PCT;
                recv_idle_pct = SEND_IDLE_PCT;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_mult = tbrd_pkg::SCALE_W'($urandom_range(255));
            set_level = tbrd_pkg::SCALE_W'($urandom_range(255));
            case (p)
                0: begin set_mode = 1'b1; set_board = 1'b1; set_mult = '1; set_level = '1; end
                1: begin set_mode = 1'b0; set_board = 1'b0; set_mult = '0; set_level = '1; end
                2: begin
                    set_mode = 1'b1; set_board = 1'b0; set_mult = 8'd20; set_level = 8'd1;
                end
                3: begin set_mode = 1'b0; set_board = 1'b1; set_mult = '1; set_level = '0; end
                4: begin set_mode = 1'b1; set_board = 1'b1; set_mult = '0; set_level = '0; end
                5: begin set_mode = 1'b0; set_board = 1'b0; end
                6: begin set_mode = 1'b1; set_board = 1'b1; end
                default: begin
                    set_mode = 1'b0; set_board = 1'b0; set_mult = tbrd_pkg::RESET_MULTIPLE;
                    set_level = tbrd_pkg::RESET_LEVEL;
                end
            endcase
            write_reg(tbrd_pkg::CFG_BREAK_TYPE_IS_DOWN, tbrd_pkg::CFG_DATA_W'(set_mode));
            write_reg(tbrd_pkg::CFG_BOARD_IS_DOWN, tbrd_pkg::CFG_DATA_W'(set_board));
            write_reg(tbrd_pkg::CFG_TENSION_MULTIPLE, set_mult);
            write_reg(tbrd_pkg::CFG_BREAK_LEVEL, set_level);
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(negedge i_clk);

            phase_start = counted_ops;
            while (counted_ops - phase_start < OPS_PER_PHASE) begin
                if ($urandom_range(9) != 0) begin
                    // well-formed run: optional begin, samples, optional stop, clamp, reads
                    for (int c = 0; c < tbrd_pkg::CHANNELS; c++) begin
                        case ($urandom_range(3))
                            0: pct[c] = 100;
                            1: pct[c] = $urandom_range(12);
                            default: pct[c] = $urandom_range(100);
                        endcase
                    end
                    if ($urandom_range(4) != 0)
                        queue_op(tbrd_pkg::FUNC_BEGIN, 1'($urandom_range(1)),
                                 tbrd_pkg::SW_W'($urandom), tbrd_pkg::SW_W'($urandom));
                    n = $urandom_range(30);
                    for (int k = 0; k < n; k++) begin
                        for (int c = 0; c < tbrd_pkg::SW_W; c++) begin
                            up[c] = (c < tbrd_pkg::CHANNELS) ? ($urandom_range(99) < pct[c])
                                                             : 1'($urandom_range(1));
                            lo[c] = (c < tbrd_pkg::CHANNELS) ? ($urandom_range(99) < pct[c])
                                                             : 1'($urandom_range(1));
                        end
                        queue_op(tbrd_pkg::FUNC_SAMPLE, 1'($urandom_range(1)), up, lo);
                    end
                    if ($urandom_range(7) == 0)
                        queue_op(tbrd_pkg::FUNC_STOP, 1'($urandom_range(1)),
                                 tbrd_pkg::SW_W'($urandom), tbrd_pkg::SW_W'($urandom));
                    queue_op(tbrd_pkg::FUNC_CLAMP, 1'($urandom_range(1)),
                             tbrd_pkg::SW_W'($urandom), tbrd_pkg::SW_W'($urandom));
                    n = $urandom_range(3);
                    for (int k = 0; k < n; k++)
                        queue_op(tbrd_pkg::FUNC_READ, 1'($urandom_range(1)),
                                 tbrd_pkg::SW_W'($urandom), tbrd_pkg::SW_W'($urandom));
                end else begin
                    n = $urandom_range(4, 1);
                    for (int k = 0; k < n; k++)
                        queue_op(tbrd_pkg::FUNC_W'($urandom_range(2 ** tbrd_pkg::FUNC_W - 1)),
                                 1'($urandom_range(1)),
                                 tbrd_pkg::SW_W'($urandom), tbrd_pkg::SW_W'($urandom));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
